>>> hw/rtl/rtbl_pkg.sv
// Shared types and constants for the route table lookup block.
package rtbl_pkg;

	// Result status codes.
	localparam logic [1:0] ST_ADDED = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_FOUND = 2'd2;
	localparam logic [1:0] ST_NONE  = 2'd3;

	// Input action codes.
	localparam logic ACT_ADD    = 1'b0;
	localparam logic ACT_LOOKUP = 1'b1;

	// A route with this metric is stored but never chosen.
	localparam logic [7:0] METRIC_NEVER = 8'd255;

	typedef struct packed {
		logic        action;
		logic [31:0] address;
		logic [31:0] mask;
		logic [31:0] next_hop;
		logic [7:0]  cost;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] found_network;
		logic [31:0] found_mask;
		logic [31:0] found_gateway;
		logic [7:0]  found_cost;
	} out_item_t;

	typedef struct packed {
		logic [31:0] network;
		logic [31:0] mask;
		logic [31:0] gateway;
		logic [7:0]  cost;
	} route_t;

	// Search token that walks the cell chain, carrying the best route so far.
	typedef struct packed {
		logic        active;
		logic [31:0] dest;
		logic        have;
		route_t      best;
	} token_t;

endpackage

>>> hw/rtl/rtbl_cell.sv
// One route table cell: stores one route and updates the passing search token.
module rtbl_cell import rtbl_pkg::*; #(
	parameter int CNT_W = 5,
	parameter int INDEX = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  route_t           wr_route,
	input  logic [CNT_W-1:0] count,
	input  token_t           tok_in,
	output token_t           tok_out
);

	localparam logic [CNT_W-1:0] MY_INDEX = CNT_W'(INDEX);

	route_t route_q;
	logic   active_q;
	token_t data_q;
	token_t tok_next;
	logic   hit;

	// The slot is written when it is the next free one.
	always_ff @(posedge clk) begin
		if (wr_en && (count == MY_INDEX)) begin
			route_q <= wr_route;
		end
	end

	// Cells are visited oldest first, so an equal metric lets the newer route take over.
	assign hit = tok_in.active && (count > MY_INDEX)
		&& ((tok_in.dest & route_q.mask) == route_q.network)
		&& (route_q.cost != METRIC_NEVER)
		&& (!tok_in.have || (route_q.cost <= tok_in.best.cost));

	// Next token payload, replaced by this cell's route on a better match.
	always_comb begin
		tok_next = tok_in;
		if (hit) begin
			tok_next.have = 1'b1;
			tok_next.best = route_q;
		end
	end

	// Token valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else begin
			active_q <= tok_in.active;
		end
	end

	// Token payload register.
	always_ff @(posedge clk) begin
		data_q <= tok_next;
	end

	always_comb begin
		tok_out        = data_q;
		tok_out.active = active_q;
	end

endmodule

>>> hw/rtl/route_table_best_metric_lookup.sv
// Top level of the IPv4 route table with lowest-metric lookup.
// Routes live in a chain of ROUTES cells, one route per cell, filled in order of addition.
// An add transfer writes the next free cell and its result is registered in the pending
// register; an add to a full table changes nothing and reports table full. A lookup sends a
// search token through the chain, one cell per cycle, and its result is registered when the
// token leaves the last cell. The next item is taken once the previous result has moved to
// the output register, so a stalled output also holds off input.
// One item is worked on at a time; a finished result may wait at the output while the
// next item is accepted.
module route_table_best_metric_lookup import rtbl_pkg::*; #(
	parameter int ROUTES = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	localparam int CNT_W = $clog2(ROUTES + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(ROUTES);

	logic [CNT_W-1:0] route_count_q;
	logic             busy_q;
	logic             pend_valid_q;
	out_item_t        pend_q;
	logic             out_valid_q;
	out_item_t        out_q;

	logic      in_xfer;
	logic      add_xfer;
	logic      lookup_xfer;
	logic      wr_en;
	logic      chain_done;
	logic      out_load;
	route_t    wr_route;
	token_t    tok [ROUTES+1];
	logic [ROUTES-1:0] active_vec;
	out_item_t add_res;
	out_item_t lookup_res;

	assign in_ready    = !busy_q && !pend_valid_q;
	assign in_xfer     = in_valid && in_ready;
	assign add_xfer    = in_xfer && (in_data.action == ACT_ADD);
	assign lookup_xfer = in_xfer && (in_data.action == ACT_LOOKUP);
	assign wr_en       = add_xfer && (route_count_q != CNT_FULL);
	assign chain_done  = tok[ROUTES].active;
	assign out_load    = pend_valid_q && (!out_valid_q || out_ready);

	assign wr_route.network = in_data.address;
	assign wr_route.mask    = in_data.mask;
	assign wr_route.gateway = in_data.next_hop;
	assign wr_route.cost    = in_data.cost;

	// A new search token enters the first cell on a lookup transfer.
	always_comb begin
		tok[0]        = '0;
		tok[0].active = lookup_xfer;
		tok[0].dest   = in_data.address;
	end

	// The row of route cells.
	for (genvar i = 0; i < ROUTES; i++) begin : g_cell
		rtbl_cell #(
			.CNT_W (CNT_W),
			.INDEX (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.wr_en    (wr_en),
			.wr_route (wr_route),
			.count    (route_count_q),
			.tok_in   (tok[i]),
			.tok_out  (tok[i+1])
		);
		assign active_vec[i] = tok[i+1].active;
	end

	// Results of an add and of a finished lookup.
	always_comb begin
		add_res        = '0;
		add_res.status = (route_count_q == CNT_FULL) ? ST_FULL : ST_ADDED;
		lookup_res     = '0;
		if (tok[ROUTES].have) begin
			lookup_res.status        = ST_FOUND;
			lookup_res.found_network = tok[ROUTES].best.network;
			lookup_res.found_mask    = tok[ROUTES].best.mask;
			lookup_res.found_gateway = tok[ROUTES].best.gateway;
			lookup_res.found_cost    = tok[ROUTES].best.cost;
		end else begin
			lookup_res.status = ST_NONE;
		end
	end

	// Control: route count, search in flight, pending and output valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			route_count_q <= '0;
			busy_q        <= 1'b0;
			pend_valid_q  <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (wr_en) begin
				route_count_q <= route_count_q + CNT_W'(1);
			end
			if (lookup_xfer) begin
				busy_q <= 1'b1;
			end else if (chain_done) begin
				busy_q <= 1'b0;
			end
			if (add_xfer || chain_done) begin
				pend_valid_q <= 1'b1;
			end else if (out_load) begin
				pend_valid_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload registers.
	always_ff @(posedge clk) begin
		if (add_xfer) begin
			pend_q <= add_res;
		end else if (chain_done) begin
			pend_q <= lookup_res;
		end
		if (out_load) begin
			out_q <= pend_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// The table never holds more routes than it has cells.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		route_count_q <= CNT_FULL)
		else $error("route count beyond table size");

	// At most one search token is in the chain.
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(active_vec))
		else $error("more than one search token in flight");

	// A token leaves the chain only while a lookup is in progress.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		chain_done |-> busy_q)
		else $error("search token without a lookup in progress");

	// A found route never carries the excluded metric.
	a_found_cost: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_q.status == ST_FOUND)) |-> (out_q.found_cost != METRIC_NEVER))
		else $error("found route with excluded metric");

endmodule

>>> bench/route_table_best_metric_lookup_tb.sv
// Self-checking testbench for the route table with lowest-metric lookup.
module route_table_best_metric_lookup_tb;
	import rtbl_pkg::*;

	localparam int ROUTES        = 16;
	localparam int RANDOM_ITEMS  = 2000;
	localparam int QUIET_TAIL    = 150;
	localparam int HOLD_AFTER    = 400;
	localparam int LONG_HOLD     = 300;
	localparam int SETTLE_CYCLES = 4 * (ROUTES + 2);

	typedef struct packed {
		logic     wait_idle;
		in_item_t item;
	} stim_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_data;

	// Items waiting to be sent and results waiting to come back.
	stim_t     pending_items[$];
	out_item_t expected_results[$];

	// Routes as the generator plans them, used to aim lookups at stored prefixes.
	route_t    plan_routes[$];

	// Shadow copy of the route table, updated on each input transfer.
	route_t    shadow_routes [ROUTES];
	int        shadow_count = 0;

	int        total_items = 0;
	int        n_results = 0;
	int        n_fail = 0;
	int        n_added = 0;
	int        n_full = 0;
	int        n_found = 0;
	int        n_none = 0;

	int        send_gap;
	logic      send_calm;
	int        stall_left;
	int        hold_left;
	logic      hold_done;
	logic      recv_calm;

	route_table_best_metric_lookup #(.ROUTES(ROUTES)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Apply one item to the shadow table and return the result it must produce.
	function automatic out_item_t apply_to_table(in_item_t item);
		out_item_t  res;
		logic [7:0] best_cost;
		res = '0;
		best_cost = METRIC_NEVER;
		if (item.action == ACT_ADD) begin
			if (shadow_count >= ROUTES) begin
				res.status = ST_FULL;
				n_full++;
			end else begin
				shadow_routes[shadow_count] = '{network: item.address, mask: item.mask,
					gateway: item.next_hop, cost: item.cost};
				shadow_count++;
				res.status = ST_ADDED;
				n_added++;
			end
		end else begin
			res.status = ST_NONE;
			// Walk newest first so that a tie on metric goes to the newest route.
			for (int i = shadow_count - 1; i >= 0; i--) begin
				if ((item.address & shadow_routes[i].mask) == shadow_routes[i].network
					&& shadow_routes[i].cost < best_cost) begin
					best_cost = shadow_routes[i].cost;
					res = '{status: ST_FOUND, found_network: shadow_routes[i].network,
						found_mask: shadow_routes[i].mask,
						found_gateway: shadow_routes[i].gateway,
						found_cost: shadow_routes[i].cost};
				end
			end
			if (res.status == ST_FOUND)
				n_found++;
			else
				n_none++;
		end
		return res;
	endfunction

	task automatic note_failure(string what);
		if (n_fail < 10)
			$display("ERROR: result %0d: %s", n_results, what);
		n_fail++;
	endtask

	task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want)
			note_failure($sformatf("%s expected %h, got %h", name, want, got));
	endtask

	task automatic compare_result(out_item_t want, out_item_t got);
		compare_field("status", 32'(want.status), 32'(got.status));
		compare_field("found_network", want.found_network, got.found_network);
		compare_field("found_mask", want.found_mask, got.found_mask);
		compare_field("found_gateway", want.found_gateway, got.found_gateway);
		compare_field("found_cost", 32'(want.found_cost), 32'(got.found_cost));
	endtask

	task automatic queue_item(logic act, logic [31:0] addr, logic [31:0] msk,
		logic [31:0] hop, logic [7:0] cst, logic hold_back);
		stim_t s;
		s.wait_idle = hold_back;
		s.item = '{action: act, address: addr, mask: msk, next_hop: hop, cost: cst};
		pending_items.push_back(s);
		if (act == ACT_ADD && plan_routes.size() < ROUTES)
			plan_routes.push_back('{network: addr, mask: msk, gateway: hop, cost: cst});
	endtask

	// Lookup destinations mostly fall inside a planned prefix, with some extremes and noise.
	function automatic logic [31:0] pick_destination();
		route_t r;
		int     sel;
		sel = $urandom_range(0, 19);
		if (sel < 15 && plan_routes.size() != 0) begin
			r = plan_routes[$urandom_range(0, plan_routes.size() - 1)];
			return (r.network & r.mask) | ($urandom() & ~r.mask);
		end else if (sel < 17) begin
			return sel[0] ? 32'hFFFF_FFFF : 32'h0;
		end
		return $urandom();
	endfunction

	// Sender: offers queued items with random gaps and records each transfer.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			send_gap <= 0;
			send_calm <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				expected_results.push_back(apply_to_table(in_data));
			if ($urandom_range(0, 149) == 0)
				send_calm <= !send_calm;
			// Pick the next offer once the current one has been taken.
			if (!in_valid || in_ready) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_items.size() == 0
					|| (pending_items[0].wait_idle && expected_results.size() != 0)) begin
					in_valid <= 1'b0;
				end else if (!send_calm && pending_items.size() > QUIET_TAIL
					&& $urandom_range(0, 5) == 0) begin
					send_gap <= $urandom_range(0, 11);
					in_valid <= 1'b0;
				end else begin
					in_data <= pending_items[0].item;
					in_valid <= 1'b1;
					pending_items.delete(0);
				end
			end
		end
	end

	// Receiver: checks each output transfer and applies stalls and one long hold.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
			hold_left <= 0;
			hold_done <= 1'b0;
			recv_calm <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				n_results++;
				if (expected_results.size() == 0) begin
					note_failure($sformatf("no result expected, got %p", out_data));
				end else begin
					compare_result(expected_results[0], out_data);
					expected_results.delete(0);
				end
			end
			if ($urandom_range(0, 149) == 0)
				recv_calm <= !recv_calm;
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else if (!hold_done && n_results >= HOLD_AFTER) begin
				// Long hold so the block backs up and stops taking input.
				hold_done <= 1'b1;
				hold_left <= LONG_HOLD - 1;
				out_ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				out_ready <= 1'b0;
			end else if (!recv_calm && n_results < total_items - QUIET_TAIL
				&& $urandom_range(0, 4) == 0) begin
				stall_left <= $urandom_range(0, 11);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		logic [31:0] prefix_seeds [4];
		logic [7:0]  cost_seeds [4];
		logic [31:0] net;
		logic [31:0] mask_bits;
		logic [7:0]  cost;
		int          plen;
		logic        hold_back;

		prefix_seeds = '{32'h0A00_0000, 32'hC0A8_0000, 32'h0A01_0000, 32'h8000_0000};
		cost_seeds = '{8'd10, 8'd50, 8'd60, METRIC_NEVER};

		// Lookups on an empty table find nothing.
		queue_item(ACT_LOOKUP, 32'h0000_0000, 32'h0, 32'h0, 8'd0, 1'b0);
		queue_item(ACT_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0, 8'd0, 1'b0);
		// A catch-all route with the never-chosen metric matches but is skipped.
		queue_item(ACT_ADD, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, METRIC_NEVER, 1'b0);
		queue_item(ACT_LOOKUP, 32'h1234_5678, 32'h0, 32'h0, 8'd0, 1'b0);
		queue_item(ACT_ADD, 32'h8000_0000, 32'h8000_0000, 32'h0101_0101, 8'd200, 1'b0);
		queue_item(ACT_LOOKUP, 32'hC0A8_0001, 32'h0, 32'h0, 8'd0, 1'b0);
		queue_item(ACT_LOOKUP, 32'h0A01_0203, 32'h0, 32'h0, 8'd0, 1'b0);
		// Two routes with equal metric: the newer one wins.
		queue_item(ACT_ADD, 32'h0A00_0000, 32'hFF00_0000, 32'h0A00_00FE, 8'd50, 1'b0);
		queue_item(ACT_ADD, 32'h0A00_0000, 32'hFF00_0000, 32'h0A00_00FD, 8'd50, 1'b0);
		queue_item(ACT_LOOKUP, 32'h0A09_0909, 32'h0, 32'h0, 8'd0, 1'b0);
		// Host route with metric zero beats the wider route.
		queue_item(ACT_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 8'd0, 1'b0);
		queue_item(ACT_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0, 8'd0, 1'b0);
		// A network with bits outside its mask can never match.
		queue_item(ACT_ADD, 32'h0A00_00FF, 32'hFF00_0000, 32'h0B0B_0B0B, 8'd1, 1'b0);
		queue_item(ACT_LOOKUP, 32'h0A00_00FF, 32'h0, 32'h0, 8'd0, 1'b0);
		// Lowest metric wins over the longer prefix.
		queue_item(ACT_ADD, 32'h0A01_0000, 32'hFFFF_0000, 32'h0A01_0001, 8'd60, 1'b0);
		queue_item(ACT_LOOKUP, 32'h0A01_0505, 32'h0, 32'h0, 8'd0, 1'b0);
		queue_item(ACT_ADD, 32'h0A02_0000, 32'hFFFF_0000, 32'h0A02_0001, 8'd10, 1'b0);
		queue_item(ACT_LOOKUP, 32'h0A02_0304, 32'h0, 32'h0, 8'd0, 1'b0);
		// Fields that a lookup ignores are all ones.
		queue_item(ACT_LOOKUP, 32'h0A02_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b0);

		// Random part: fill the table, then mostly lookups plus adds to a full table.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			hold_back = (i == 0) || ($urandom_range(0, 299) == 0);
			if ($urandom_range(0, 99) < (plan_routes.size() < ROUTES ? 25 : 6)) begin
				plen = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 32) : $urandom_range(8, 30);
				mask_bits = (plen == 0) ? 32'h0 : (~32'h0 << (32 - plen));
				net = prefix_seeds[$urandom_range(0, 3)] | ($urandom() & 32'h00FF_FFFF);
				if ($urandom_range(0, 9) != 0)
					net = net & mask_bits;
				cost = ($urandom_range(0, 2) == 0) ? cost_seeds[$urandom_range(0, 3)]
					: 8'($urandom_range(0, 255));
				// Once the table is full every field is pure noise.
				if (plan_routes.size() >= ROUTES) begin
					net = $urandom();
					mask_bits = $urandom();
					cost = 8'($urandom());
				end
				queue_item(ACT_ADD, net, mask_bits, $urandom(), cost, hold_back);
			end else begin
				queue_item(ACT_LOOKUP, pick_destination(), $urandom(), $urandom(),
					8'($urandom()), hold_back);
			end
		end
		total_items = pending_items.size();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d transfers: %0d routes stored, %0d adds refused by a full table.",
			total_items, n_added, n_full);
		$display("Lookups: %0d found a route, %0d found none; %0d mismatches.",
			n_found, n_none, n_fail);
		if (n_fail == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#6000000;
		$display("Timed out with %0d results outstanding.", expected_results.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule
